// File: design/tehs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tehs_pkg: shared types and codes
// Function codes, result status codes, FSM states and the controller to
// datapath command and status structs of the event scheduler.
// ----------------------------------------------------------------------------
package tehs_pkg;

  localparam int unsigned FuncBits   = 2;
  localparam int unsigned StatusBits = 3;
  localparam int unsigned CyclesBits = 16;

  typedef enum logic [FuncBits-1:0] {
    FUNC_INSERT  = 2'd0,
    FUNC_ADVANCE = 2'd1,
    FUNC_FIND    = 2'd2,
    FUNC_NONE    = 2'd3
  } func_e;

  typedef enum logic [StatusBits-1:0] {
    ST_FIRED     = 3'd0,
    ST_DONE      = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_INSERTED  = 3'd4,
    ST_REJECTED  = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,     // issue parent read
    S_INS_CMP,    // compare parent, maybe swap
    S_ADV_CHK,    // root read back, check due
    S_ADV_MOVE,   // move last entry to root
    S_SD_RD,      // issue child reads
    S_SD_CMP,     // compare children, maybe swap
    S_FIND_RD,
    S_FIND_CMP,
    S_OUT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic    load;        // capture input beat
    logic    ins_write;   // write new entry at count, bump count
    logic    ins_setup;   // pos := count-1
    logic    rd_parent;
    logic    up_step;     // swap with parent if greater
    logic    rd_root;
    logic    pop;         // emit root, move last entry to root
    logic    sd_setup;    // pos := 0
    logic    rd_kids;
    logic    down_step;
    logic    find_setup;
    logic    rd_find;
    logic    find_step;
    logic    commit_time;
    logic    emit;        // present result
    status_e status;
    logic    last;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    func_e func;
    logic  full;
    logic  empty;
    logic  root_due;
    logic  up_more;       // swap happened and pos still above root
    logic  up_can;        // pos > 0
    logic  down_more;
    logic  find_hit;
    logic  find_end;
    logic  out_busy;
  } sts_t;

endpackage

// File: design/tehs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tehs_in_if / tehs_out_if: valid/ready channels
// Input beat carries one command, output beat carries one result.
// ----------------------------------------------------------------------------
interface tehs_in_if #(
  parameter int unsigned TimeBits = 48,
  parameter int unsigned TypeBits = 4
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            func;
  logic [TypeBits-1:0]   event_type;
  logic [TimeBits-1:0]   event_time;
  logic [15:0]           cycles;
  modport source (output valid, func, event_type, event_time, cycles, input ready);
  modport sink   (input valid, func, event_type, event_time, cycles, output ready);
endinterface

interface tehs_out_if #(
  parameter int unsigned TimeBits = 48,
  parameter int unsigned TypeBits = 4
);
  logic                  valid;
  logic                  ready;
  logic [2:0]            result_status;
  logic [TypeBits-1:0]   out_type;
  logic [TimeBits-1:0]   out_time;
  logic                  last_of_run;
  modport source (output valid, result_status, out_type, out_time, last_of_run,
                  input ready);
  modport sink   (input valid, result_status, out_type, out_time, last_of_run,
                  output ready);
endinterface

// File: design/tehs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tehs_ctrl: scheduler sequencer
// Walks insert sift-up, advance pop/sift-down and find scan one step a time.
// ----------------------------------------------------------------------------
module tehs_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  tehs_pkg::sts_t  sts_i,
  output tehs_pkg::cmd_t  cmd_o
);
  import tehs_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.status = ST_DONE;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = !sts_i.out_busy;
        if (in_valid_i && !sts_i.out_busy) begin
          cmd_o.load = 1'b1;
          // captured func only valid next cycle: decode there
          state_d = S_OUT;
        end
      end
      // S_OUT right after load dispatches on captured func
      S_OUT: begin
        state_d = S_IDLE;
        case (sts_i.func)
          FUNC_INSERT: begin
            if (sts_i.full) begin
              cmd_o.emit = 1'b1; cmd_o.status = ST_REJECTED; cmd_o.last = 1'b1;
            end else begin
              cmd_o.ins_write = 1'b1;
              state_d = S_INS_RD;
            end
          end
          FUNC_ADVANCE: begin
            cmd_o.rd_root = 1'b1;
            state_d = S_ADV_CHK;
          end
          FUNC_FIND: begin
            cmd_o.find_setup = 1'b1;
            state_d = S_FIND_RD;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_INS_RD: begin
        cmd_o.ins_setup = 1'b0;
        cmd_o.rd_parent = 1'b1;
        state_d = S_INS_CMP;
        if (!sts_i.up_can) begin
          cmd_o.rd_parent = 1'b0;
          cmd_o.emit = 1'b1; cmd_o.status = ST_INSERTED; cmd_o.last = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_INS_CMP: begin
        cmd_o.up_step = 1'b1;
        state_d = S_INS_RD;
        if (!sts_i.up_more) begin
          cmd_o.emit = 1'b1; cmd_o.status = ST_INSERTED; cmd_o.last = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_ADV_CHK: begin
        if (!sts_i.out_busy) begin
          if (!sts_i.empty && sts_i.root_due) begin
            cmd_o.emit = 1'b1; cmd_o.status = ST_FIRED; cmd_o.pop = 1'b1;
            state_d = S_SD_RD;
          end else begin
            cmd_o.emit = 1'b1; cmd_o.status = ST_DONE; cmd_o.last = 1'b1;
            cmd_o.commit_time = 1'b1;
            state_d = S_IDLE;
          end
        end
      end
      S_SD_RD: begin
        cmd_o.rd_kids = 1'b1;
        state_d = S_SD_CMP;
      end
      S_SD_CMP: begin
        cmd_o.down_step = 1'b1;
        if (sts_i.down_more) state_d = S_SD_RD;
        else begin
          cmd_o.rd_root = 1'b1;
          state_d = S_ADV_CHK;
        end
      end
      S_FIND_RD: begin
        if (sts_i.find_end) begin
          cmd_o.emit = 1'b1; cmd_o.status = ST_NOT_FOUND; cmd_o.last = 1'b1;
          state_d = S_IDLE;
        end else begin
          cmd_o.rd_find = 1'b1;
          state_d = S_FIND_CMP;
        end
      end
      S_FIND_CMP: begin
        if (sts_i.find_hit) begin
          cmd_o.emit = 1'b1; cmd_o.status = ST_FOUND; cmd_o.last = 1'b1;
          state_d = S_IDLE;
        end else begin
          cmd_o.find_step = 1'b1;
          state_d = S_FIND_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// File: design/tehs_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tehs_dpath: heap memory, counters and result register
// Heap array is a register file with registered read ports; the sift
// position, count and time live here. One output register holds a beat.
// ----------------------------------------------------------------------------
module tehs_dpath #(
  parameter int unsigned Capacity = 16,
  parameter int unsigned TimeBits = 48,
  parameter int unsigned TypeBits = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [1:0]            in_func_i,
  input  logic [TypeBits-1:0]   in_type_i,
  input  logic [TimeBits-1:0]   in_time_i,
  input  logic [15:0]           in_cycles_i,
  input  tehs_pkg::cmd_t        cmd_i,
  output tehs_pkg::sts_t        sts_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [2:0]            out_status_o,
  output logic [TypeBits-1:0]   out_type_o,
  output logic [TimeBits-1:0]   out_time_o,
  output logic                  out_last_o
);
  import tehs_pkg::*;

  localparam int unsigned AW = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned CW = $clog2(Capacity + 1);
  localparam int unsigned PW = AW + 2;  // room for 2*pos+2

  typedef struct packed {
    logic [TypeBits-1:0] ty;
    logic [TimeBits-1:0] tm;
  } ent_t;

  ent_t heap_q [Capacity];

  logic [CW-1:0]       count_q;
  logic [TimeBits-1:0] now_q, next_q;
  logic [1:0]          func_q;
  logic [TypeBits-1:0] ty_q;
  logic [TimeBits-1:0] tm_q;
  logic [AW-1:0]       pos_q;
  logic [CW-1:0]       fidx_q;
  ent_t                rd_a_q, rd_b_q, rd_c_q;  // pos / parent or left / right
  logic                l_ok_q, r_ok_q;
  logic                ov_q;
  logic [2:0]          ost_q;
  logic [TypeBits-1:0] oty_q;
  logic [TimeBits-1:0] otm_q;
  logic                olast_q;

  logic [AW-1:0] parent;
  logic [PW-1:0] lch, rch;
  logic [CW-1:0] cnt_m1;
  logic          up_swap;
  logic          pick_r, pick_l;
  logic [AW-1:0] best;

  assign parent = AW'((pos_q - 1'b1) >> 1);
  assign lch    = PW'({pos_q, 1'b1});
  assign rch    = PW'({pos_q, 1'b0}) + PW'(2);
  assign cnt_m1 = count_q - 1'b1;
  assign up_swap = rd_b_q.tm > rd_a_q.tm;

  // left beats pos on strict less; right beats current best on strict less
  always_comb begin
    pick_l = l_ok_q && (rd_b_q.tm < rd_a_q.tm);
    pick_r = r_ok_q && (rd_c_q.tm < (pick_l ? rd_b_q.tm : rd_a_q.tm));
    best   = pick_r ? AW'(rch) : (pick_l ? AW'(lch) : pos_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= in_func_i;
      ty_q   <= in_type_i;
      tm_q   <= in_time_i;
      next_q <= now_q + TimeBits'(in_cycles_i);
    end
    if (cmd_i.ins_write) begin
      heap_q[AW'(count_q)] <= '{ty: ty_q, tm: tm_q};
      pos_q <= AW'(count_q);
    end
    if (cmd_i.rd_parent) begin
      rd_a_q <= heap_q[pos_q];
      rd_b_q <= heap_q[parent];
    end
    if (cmd_i.up_step && up_swap) begin
      heap_q[parent] <= rd_a_q;
      heap_q[pos_q]  <= rd_b_q;
      pos_q <= parent;
    end
    if (cmd_i.rd_root) rd_a_q <= heap_q[0];
    if (cmd_i.pop) begin
      heap_q[0] <= heap_q[AW'(cnt_m1)];
      pos_q <= '0;
    end
    if (cmd_i.rd_kids) begin
      rd_a_q <= heap_q[pos_q];
      rd_b_q <= heap_q[AW'(lch)];
      rd_c_q <= heap_q[AW'(rch)];
      l_ok_q <= lch < PW'(count_q);
      r_ok_q <= rch < PW'(count_q);
    end
    if (cmd_i.down_step && best != pos_q) begin
      heap_q[best]  <= rd_a_q;
      heap_q[pos_q] <= pick_r ? rd_c_q : rd_b_q;
      pos_q <= best;
    end
    if (cmd_i.find_setup) fidx_q <= '0;
    if (cmd_i.rd_find) rd_a_q <= heap_q[AW'(fidx_q)];
    if (cmd_i.find_step) fidx_q <= fidx_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      now_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      if (cmd_i.ins_write) count_q <= count_q + 1'b1;
      if (cmd_i.pop)       count_q <= cnt_m1;
      if (cmd_i.commit_time) now_q <= next_q;
      if (cmd_i.emit)      ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      ost_q   <= cmd_i.status;
      olast_q <= cmd_i.last;
      case (cmd_i.status)
        ST_FIRED:     begin oty_q <= rd_a_q.ty; otm_q <= rd_a_q.tm; end
        ST_DONE:      begin oty_q <= '0;        otm_q <= next_q;    end
        ST_FOUND:     begin oty_q <= ty_q;      otm_q <= rd_a_q.tm; end
        ST_NOT_FOUND: begin oty_q <= ty_q;      otm_q <= '0;        end
        default:      begin oty_q <= ty_q;      otm_q <= tm_q;      end
      endcase
    end
  end

  always_comb begin
    sts_o.func      = func_e'(func_q);
    sts_o.full      = count_q == CW'(Capacity);
    sts_o.empty     = count_q == '0;
    sts_o.root_due  = rd_a_q.tm <= next_q;
    sts_o.up_can    = pos_q != '0;
    sts_o.up_more   = up_swap && (parent != '0);
    sts_o.down_more = best != pos_q;
    sts_o.find_hit  = rd_a_q.ty == ty_q;
    sts_o.find_end  = fidx_q >= count_q;
    sts_o.out_busy  = ov_q && !out_ready_i;
  end

  assign out_valid_o  = ov_q;
  assign out_status_o = ost_q;
  assign out_type_o   = oty_q;
  assign out_time_o   = otm_q;
  assign out_last_o   = olast_q;

endmodule

// File: design/timed_event_min_heap_scheduler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_event_min_heap_scheduler_unit: min-heap event scheduler
// Channel   Dir  Payload
// in_ch     in   func, event_type, event_time, cycles
// out_ch    out  result_status, out_type, out_time, last_of_run
//
// One command at a time. Insert: write at the end, then a parent read and
// compare per level until no swap or the root; full: rejected without a write.
// Advance: root read and due check, then per popped event a pop and child
// read/compare rounds (the last round swaps nothing) on the single heap
// array, one level per round. Find: one read and compare per entry.
// Reset clears count, time and control; heap contents are don't care.
// A stalled output beat holds the sequencer at its next emit.
// ----------------------------------------------------------------------------
module timed_event_min_heap_scheduler_unit #(
  parameter int unsigned Capacity = 16,
  parameter int unsigned TimeBits = 48,
  parameter int unsigned TypeBits = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  tehs_in_if.sink    in_ch,
  tehs_out_if.source out_ch
);
  import tehs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tehs_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tehs_dpath #(.Capacity(Capacity), .TimeBits(TimeBits), .TypeBits(TypeBits)) u_dpath (
    .clk_i, .rst_ni,
    .in_func_i    (in_ch.func),
    .in_type_i    (in_ch.event_type),
    .in_time_i    (in_ch.event_time),
    .in_cycles_i  (in_ch.cycles),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_ch.valid),
    .out_ready_i  (out_ch.ready),
    .out_status_o (out_ch.result_status),
    .out_type_o   (out_ch.out_type),
    .out_time_o   (out_ch.out_time),
    .out_last_o   (out_ch.last_of_run)
  );

endmodule

// File: design/tehs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tehs_checker: port-level checks
// Watches the channel ports of the scheduler.
// ----------------------------------------------------------------------------
module tehs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_status,
  input logic       out_last
);
  import tehs_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result beat dropped while stalled");

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (out_status == ST_FIRED) |-> !out_last)
    else $error("fired beat marked last");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("second command taken while busy");

  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (out_status == ST_DONE || out_status == ST_FOUND) |-> out_last)
    else $error("terminal beat not last");

endmodule

bind timed_event_min_heap_scheduler_unit tehs_checker u_chk (
  .clk_i, .rst_ni,
  .in_valid (in_ch.valid), .in_ready (in_ch.ready),
  .out_valid (out_ch.valid), .out_ready (out_ch.ready),
  .out_status (out_ch.result_status), .out_last (out_ch.last_of_run)
);

// File: bench/tehs_tb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tehs_tb_checker: scoreboard for the event scheduler
// Watches both channels, keeps a shadow heap, current time and event count,
// queues the results each accepted command must cause and compares every
// result beat field by field against the oldest one queued.
// ----------------------------------------------------------------------------
module tehs_tb_checker #(
  parameter int unsigned Capacity = 16,
  parameter int unsigned TimeBits = 48,
  parameter int unsigned TypeBits = 4
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  tehs_in_if.sink  in_mon,
  tehs_out_if.sink out_mon,
  output int       err_cnt_o,
  output int       pending_o
);
  import tehs_pkg::*;

  typedef struct packed {
    logic [TypeBits-1:0] etype;
    logic [TimeBits-1:0] etime;
  } slot_t;

  typedef struct packed {
    status_e             status;
    logic [TypeBits-1:0] etype;
    logic [TimeBits-1:0] etime;
    logic                last;
  } res_t;

  slot_t               heap_q[Capacity];
  int unsigned         count_q;
  logic [TimeBits-1:0] now_q;
  res_t                res_q[$];

  task automatic push_res(status_e st, logic [TypeBits-1:0] ty,
                          logic [TimeBits-1:0] tm, logic last);
    res_t r;
    r.status = st; r.etype = ty; r.etime = tm; r.last = last;
    res_q.push_back(r);
  endtask

  task automatic schedule_cmd(func_e fn, logic [TypeBits-1:0] ty,
                              logic [TimeBits-1:0] tm, logic [15:0] cyc);
    int unsigned p, l, r, b;
    slot_t t;
    logic [TimeBits-1:0] nxt;
    bit hit;
    case (fn)
      FUNC_INSERT: begin
        if (count_q >= Capacity) begin
          push_res(ST_REJECTED, ty, tm, 1'b1);
        end else begin
          heap_q[count_q] = '{etype: ty, etime: tm};
          p = count_q;
          count_q++;
          while (p > 0 && heap_q[(p-1)/2].etime > heap_q[p].etime) begin
            t = heap_q[p]; heap_q[p] = heap_q[(p-1)/2]; heap_q[(p-1)/2] = t;
            p = (p - 1) / 2;
          end
          push_res(ST_INSERTED, ty, tm, 1'b1);
        end
      end
      FUNC_ADVANCE: begin
        nxt = now_q + TimeBits'(cyc);
        while (count_q > 0 && heap_q[0].etime <= nxt) begin
          push_res(ST_FIRED, heap_q[0].etype, heap_q[0].etime, 1'b0);
          count_q--;
          heap_q[0] = heap_q[count_q];
          p = 0;
          forever begin
            l = 2*p + 1; r = 2*p + 2; b = p;
            if (l < count_q && heap_q[l].etime < heap_q[b].etime) b = l;
            if (r < count_q && heap_q[r].etime < heap_q[b].etime) b = r;
            if (b == p) break;
            t = heap_q[p]; heap_q[p] = heap_q[b]; heap_q[b] = t;
            p = b;
          end
        end
        now_q = nxt;
        push_res(ST_DONE, '0, nxt, 1'b1);
      end
      FUNC_FIND: begin
        hit = 1'b0;
        for (int i = 0; i < count_q; i++) begin
          if (!hit && heap_q[i].etype == ty) begin
            push_res(ST_FOUND, ty, heap_q[i].etime, 1'b1);
            hit = 1'b1;
          end
        end
        if (!hit) push_res(ST_NOT_FOUND, ty, '0, 1'b1);
      end
      default: ;  // no result
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t e;
    if (!rst_ni) begin
      count_q   = 0;
      now_q     = '0;
      err_cnt_o = 0;
      res_q.delete();
      pending_o = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (res_q.size() == 0) begin
          err_cnt_o++;
          if (err_cnt_o <= 10)
            $display("%0t: unexpected result beat st=%0d ty=%0h tm=%0h", $time,
                     out_mon.result_status, out_mon.out_type, out_mon.out_time);
        end else begin
          e = res_q.pop_front();
          if (out_mon.result_status !== e.status || out_mon.out_type !== e.etype ||
              out_mon.out_time !== e.etime || out_mon.last_of_run !== e.last) begin
            err_cnt_o++;
            if (err_cnt_o <= 10)
              $display({"%0t: mismatch exp st=%0d ty=%0h tm=%0h l=%0b",
                        " got st=%0d ty=%0h tm=%0h l=%0b"},
                       $time, e.status, e.etype, e.etime, e.last, out_mon.result_status,
                       out_mon.out_type, out_mon.out_time, out_mon.last_of_run);
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        schedule_cmd(func_e'(in_mon.func), in_mon.event_type, in_mon.event_time,
                     in_mon.cycles);
      pending_o = res_q.size();
    end
  end

endmodule

// File: bench/tb_timed_event_min_heap_scheduler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_timed_event_min_heap_scheduler_unit: scheduler testbench top
// Drives directed then random insert/advance/find/none beats with random idle and
// stall bursts; the checker predicts and compares, this module gives verdict.
// ----------------------------------------------------------------------------
module tb_timed_event_min_heap_scheduler_unit;
  import tehs_pkg::*;

  localparam int unsigned Capacity  = 16;
  localparam int unsigned TimeBits  = 48;
  localparam int unsigned TypeBits  = 4;
  localparam int          NumRandom = 400;
  localparam int          CalmTail  = 60;     // last beats sent without idling
  // worst case per beat is ~17 results, each possibly behind a ready stall burst,
  // plus sift work; the per-beat budget in CycleLimit is several times that
  localparam longint      CycleLimit = 64'd2000 * (NumRandom + 40);

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   err_cnt, pending;
  longint cyc_cnt = 0;
  logic   calm = 1'b0;

  tehs_in_if  #(.TimeBits(TimeBits), .TypeBits(TypeBits)) in_ch ();
  tehs_out_if #(.TimeBits(TimeBits), .TypeBits(TypeBits)) out_ch ();

  timed_event_min_heap_scheduler_unit #(
    .Capacity(Capacity), .TimeBits(TimeBits), .TypeBits(TypeBits)
  ) i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  tehs_tb_checker #(
    .Capacity(Capacity), .TimeBits(TimeBits), .TypeBits(TypeBits)
  ) i_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_mon(in_ch.sink), .out_mon(out_ch.sink),
    .err_cnt_o(err_cnt), .pending_o(pending)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side: ready stalls in bursts, none in the calm tail
  initial begin
    int n;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 14);
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // one beat, held until accepted; optional idle burst first
  task automatic send_cmd(func_e fn, logic [TypeBits-1:0] ty,
                          logic [TimeBits-1:0] tm, logic [15:0] cyc);
    int n;
    if (!calm && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 14);
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.func       <= fn;
    in_ch.event_type <= ty;
    in_ch.event_time <= tm;
    in_ch.cycles     <= cyc;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  function automatic logic [TimeBits-1:0] rand_time();
    return TimeBits'({$urandom, $urandom});
  endfunction

  initial begin
    int unsigned r;
    func_e fn;
    logic [TimeBits-1:0] base;
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_INSERT;
    in_ch.event_type = '0;
    in_ch.event_time = '0;
    in_ch.cycles = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty find/advance, fill past capacity, extremes, drain
    send_cmd(FUNC_FIND, 4'hF, '0, '0);
    send_cmd(FUNC_ADVANCE, '0, '0, 16'd0);
    send_cmd(FUNC_NONE, 4'h5, '1, 16'hFFFF);
    for (int i = 0; i < Capacity; i++)
      send_cmd(FUNC_INSERT, TypeBits'(i), TimeBits'(Capacity - i) * 7, '0);
    send_cmd(FUNC_INSERT, 4'hF, '1, '0);                 // heap full
    send_cmd(FUNC_FIND, 4'h3, '0, '0);
    send_cmd(FUNC_ADVANCE, '0, '0, 16'hFFFF);            // drains all
    send_cmd(FUNC_INSERT, 4'hA, '1, '0);
    send_cmd(FUNC_INSERT, 4'h0, '0, '0);
    send_cmd(FUNC_FIND, 4'h9, '0, '0);

    // random: time near current so events fire; occasional far/wrap times
    base = 48'h1_0000 + 48'hFFFF;
    for (int k = 0; k < NumRandom; k++) begin
      if (k == NumRandom - CalmTail) calm = 1'b1;
      r = $urandom_range(0, 99);
      fn = (r < 55) ? FUNC_INSERT : (r < 80) ? FUNC_ADVANCE :
           (r < 97) ? FUNC_FIND : FUNC_NONE;
      if (fn == FUNC_INSERT && $urandom_range(0, 9) == 0)
        send_cmd(fn, TypeBits'($urandom), rand_time(), 16'($urandom));
      else
        send_cmd(fn, TypeBits'($urandom), base + 48'($urandom_range(0, 4000)),
                 16'($urandom_range(0, 1200)));
      if (fn == FUNC_ADVANCE) base = base + 48'd600;
    end
    // one event near the top of the time range, then a long advance
    send_cmd(FUNC_INSERT, 4'h1, 48'hFFFF_FFFF_FFF0, '0);
    send_cmd(FUNC_ADVANCE, '0, '0, 16'hFFFF);
    in_ch.valid <= 1'b0;

    // let the checker log the last accepted beat before polling
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: files.f
design/tehs_pkg.sv
design/tehs_if.sv
design/tehs_ctrl.sv
design/tehs_dpath.sv
design/timed_event_min_heap_scheduler_unit.sv
design/tehs_checker.sv
bench/tehs_tb_checker.sv
bench/tb_timed_event_min_heap_scheduler_unit.sv
